@@ rtl/tacp_pkg.sv @@
// Shared types, sizes and helpers for the three-angle command parser.
// No dependencies; every other file refers to this package by scoped names.
package tacp_pkg;

    localparam int ANGLE_COUNT = 3;           // angles per line, 1..8
    localparam int OUT_ANGLES  = 3;           // angle fields in a result
    localparam int ANGLE_W     = 20;
    localparam int WHOLE_W     = 14;
    localparam int FRAC_W      = 7;
    localparam int FCNT_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int IDX_W       = $clog2(ANGLE_COUNT + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - OUT_ANGLES * ANGLE_W;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT_RESET   = ANGLE_W'(36000);
    localparam logic               CFG_IDX_ANGLE_LIMIT = 1'b0;
    localparam logic [FCNT_W-1:0]  FRAC_DIGITS_MAX     = FCNT_W'(2);
    localparam logic [FCNT_W-1:0]  FRAC_ONE_DIGIT      = FCNT_W'(1);

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_DOT,
        TK_SEP,
        TK_EOL,
        TK_OTHER
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_token;

    typedef struct packed {
        logic               ok;
        logic [ANGLE_W-1:0] value;
    } t_finish;

    typedef struct packed {
        logic                                line_valid;
        logic [OUT_ANGLES-1:0][ANGLE_W-1:0]  angles;
    } t_result;

    // Close one angle: whole*100 + fraction (tenths scaled), then range check.
    function automatic t_finish finish_angle(
        input logic [WHOLE_W-1:0] whole,
        input logic [FRAC_W-1:0]  frac,
        input logic [FCNT_W-1:0]  fcnt,
        input logic               seen,
        input logic [IDX_W-1:0]   idx,
        input logic [ANGLE_W-1:0] limit
    );
        logic [ANGLE_W:0]  w_ext;
        logic [ANGLE_W:0]  val;
        logic [FRAC_W-1:0] f;
        t_finish           r;
        w_ext   = {{(ANGLE_W + 1 - WHOLE_W){1'b0}}, whole};
        f       = (fcnt == FRAC_ONE_DIGIT) ? FRAC_W'((frac << 3) + (frac << 1)) : frac;
        val     = (w_ext << 6) + (w_ext << 5) + (w_ext << 2)
                + {{(ANGLE_W + 1 - FRAC_W){1'b0}}, f};
        r.ok    = seen && (val <= {1'b0, limit}) && (idx < IDX_W'(ANGLE_COUNT));
        r.value = val[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/tacp_front.sv @@
// Front end: takes stream bytes and classifies each into a parser token.
// Uses tacp_pkg; feeds tacp_queue.
module tacp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tacp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                i_q_full,
    output logic                                o_push,
    output tacp_pkg::t_token                    o_tok
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic [7:0] w_byte;
    logic [7:0] w_off;
    logic       r_up;   // holds ready low while in reset

    assign w_byte = s_axis_tdata[7:0];
    assign w_off  = w_byte - CH_ZERO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= 1'b0;
        end else begin
            r_up <= 1'b1;
        end
    end

    assign s_axis_tready = r_up && !i_q_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_tok.last  = s_axis_tlast;
        o_tok.digit = w_off[tacp_pkg::DIGIT_W-1:0];
        if (w_byte >= CH_ZERO && w_byte <= CH_NINE) begin
            o_tok.kind = tacp_pkg::TK_DIGIT;
        end else if (w_byte == CH_DOT) begin
            o_tok.kind = tacp_pkg::TK_DOT;
        end else if (w_byte == CH_SPACE || w_byte == CH_TAB ||
                     w_byte == CH_COMMA || w_byte == CH_SEMI) begin
            o_tok.kind = tacp_pkg::TK_SEP;
        end else if (w_byte == CH_CR || w_byte == CH_LF) begin
            o_tok.kind = tacp_pkg::TK_EOL;
        end else begin
            o_tok.kind = tacp_pkg::TK_OTHER;
        end
    end

endmodule

@@ rtl/tacp_queue.sv @@
// Short token queue that decouples the classifier from the parser.
// Uses tacp_pkg.
module tacp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tacp_pkg::t_token i_tok,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output tacp_pkg::t_token o_tok
);

    localparam logic [tacp_pkg::QPTR_W-1:0] PTR_LAST = tacp_pkg::QPTR_W'(tacp_pkg::QUEUE_DEPTH - 1);

    tacp_pkg::t_token                r_mem [tacp_pkg::QUEUE_DEPTH];
    logic [tacp_pkg::QPTR_W-1:0]     r_wr;
    logic [tacp_pkg::QPTR_W-1:0]     r_rd;
    logic [tacp_pkg::QPTR_W:0]       r_cnt;

    assign o_full  = (r_cnt == (tacp_pkg::QPTR_W + 1)'(tacp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_tok;
                r_wr        <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/tacp_back.sv @@
// Back end: token parser state, end-of-line closing stage and result register.
// Uses tacp_pkg; consumes tokens from tacp_queue.
module tacp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tacp_pkg::ANGLE_W-1:0]   i_limit,
    input  logic                           i_tok_valid,
    input  tacp_pkg::t_token               i_tok,
    output logic                           o_pop,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output tacp_pkg::t_result              o_res
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_WHOLE,
        PH_FRAC,
        PH_TRAIL,
        PH_FAIL
    } t_phase;

    localparam int AW = tacp_pkg::ANGLE_W;
    localparam int WW = tacp_pkg::WHOLE_W;
    localparam int FW = tacp_pkg::FRAC_W;
    localparam int CW = tacp_pkg::FCNT_W;
    localparam int IW = tacp_pkg::IDX_W;
    localparam int N  = tacp_pkg::ANGLE_COUNT;
    localparam logic [IW-1:0] IDX_END = IW'(tacp_pkg::ANGLE_COUNT);

    // parse state
    t_phase          r_phase, n_phase;
    logic [IW-1:0]   r_idx, n_idx;
    logic [WW-1:0]   r_whole, n_whole;
    logic [FW-1:0]   r_frac, n_frac;
    logic [CW-1:0]   r_fcnt, n_fcnt;
    logic            r_seen, n_seen;
    logic [AW-1:0]   r_angles [N];
    logic [AW-1:0]   n_angles [N];

    // end-of-line snapshot
    logic            r_s_valid;
    t_phase          r_s_phase;
    logic [IW-1:0]   r_s_idx;
    logic [WW-1:0]   r_s_whole;
    logic [FW-1:0]   r_s_frac;
    logic [CW-1:0]   r_s_fcnt;
    logic            r_s_seen;
    logic [AW-1:0]   r_s_angles [N];

    // result register
    logic              r_o_valid;
    tacp_pkg::t_result r_o_res, n_o_res;

    tacp_pkg::t_finish w_fin, w_fin_s;
    logic [WW+3:0]     w_wsum;
    logic              w_do_idle;
    t_phase            w_idle_ph;
    logic              w_c_ready, w_b_ready, w_take, w_s_open;

    assign w_c_ready = !r_o_valid || i_res_ready;
    assign w_b_ready = !r_s_valid || w_c_ready;
    assign w_take    = i_tok_valid && (!i_tok.last || w_b_ready);
    assign o_pop     = w_take;

    assign w_fin  = tacp_pkg::finish_angle(r_whole, r_frac, r_fcnt, r_seen, r_idx, i_limit);
    assign w_wsum = ({4'b0, r_whole} << 3) + ({4'b0, r_whole} << 1)
                  + {{WW{1'b0}}, i_tok.digit};

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_whole   = r_whole;
        n_frac    = r_frac;
        n_fcnt    = r_fcnt;
        n_seen    = r_seen;
        n_angles  = r_angles;
        w_do_idle = 1'b0;
        w_idle_ph = r_phase;
        case (r_phase)
            PH_WHOLE, PH_FRAC: begin
                if (i_tok.kind == tacp_pkg::TK_DIGIT) begin
                    if (r_phase == PH_WHOLE) begin
                        // saturate the whole part
                        n_whole = (w_wsum > {4'b0, {WW{1'b1}}}) ? {WW{1'b1}} : w_wsum[WW-1:0];
                    end else if (r_fcnt < tacp_pkg::FRAC_DIGITS_MAX) begin
                        n_frac = FW'((r_frac << 3) + (r_frac << 1))
                               + {{(FW - tacp_pkg::DIGIT_W){1'b0}}, i_tok.digit};
                        n_fcnt = r_fcnt + 1'b1;
                        n_seen = 1'b1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end else if (r_phase == PH_WHOLE && i_tok.kind == tacp_pkg::TK_DOT) begin
                    n_phase = PH_FRAC;
                end else if (w_fin.ok) begin
                    for (int k = 0; k < N; k++) begin
                        if (r_idx == IW'(k)) begin
                            n_angles[k] = w_fin.value;
                        end
                    end
                    n_idx     = r_idx + 1'b1;
                    n_whole   = '0;
                    n_frac    = '0;
                    n_fcnt    = '0;
                    n_seen    = 1'b0;
                    w_do_idle = 1'b1;
                    w_idle_ph = (r_idx + 1'b1 == IDX_END) ? PH_TRAIL : PH_SKIP;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_SKIP, PH_TRAIL: begin
                w_do_idle = 1'b1;
            end
            default: begin
            end
        endcase

        // between angles, or after the last one
        if (w_do_idle) begin
            if (w_idle_ph == PH_TRAIL) begin
                n_phase = (i_tok.kind == tacp_pkg::TK_SEP || i_tok.kind == tacp_pkg::TK_EOL)
                        ? PH_TRAIL : PH_FAIL;
            end else begin
                case (i_tok.kind)
                    tacp_pkg::TK_SEP: n_phase = PH_SKIP;
                    tacp_pkg::TK_DIGIT: begin
                        n_phase = PH_WHOLE;
                        n_whole = {{(WW - tacp_pkg::DIGIT_W){1'b0}}, i_tok.digit};
                        n_seen  = 1'b1;
                    end
                    tacp_pkg::TK_DOT: n_phase = PH_FRAC;
                    default: n_phase = PH_FAIL;
                endcase
            end
        end
    end

    // closing stage: finish an open angle and decide the line
    assign w_fin_s  = tacp_pkg::finish_angle(r_s_whole, r_s_frac, r_s_fcnt, r_s_seen,
                                             r_s_idx, i_limit);
    assign w_s_open = (r_s_phase == PH_WHOLE) || (r_s_phase == PH_FRAC);
    assign n_o_res.line_valid = (r_s_phase == PH_TRAIL) ||
                                (w_s_open && w_fin_s.ok && (r_s_idx + 1'b1 == IDX_END));

    for (genvar g = 0; g < tacp_pkg::OUT_ANGLES; g++) begin : g_out
        if (g < N) begin : g_used
            assign n_o_res.angles[g] = !n_o_res.line_valid ? '0 :
                                       (w_s_open && r_s_idx == IW'(g)) ? w_fin_s.value :
                                       r_s_angles[g];
        end else begin : g_unused
            assign n_o_res.angles[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_idx     <= '0;
            r_whole   <= '0;
            r_frac    <= '0;
            r_fcnt    <= '0;
            r_seen    <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_take) begin
                if (i_tok.last) begin
                    r_s_phase  <= n_phase;
                    r_s_idx    <= n_idx;
                    r_s_whole  <= n_whole;
                    r_s_frac   <= n_frac;
                    r_s_fcnt   <= n_fcnt;
                    r_s_seen   <= n_seen;
                    r_s_angles <= n_angles;
                    r_phase    <= PH_SKIP;
                    r_idx      <= '0;
                    r_whole    <= '0;
                    r_frac     <= '0;
                    r_fcnt     <= '0;
                    r_seen     <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_idx      <= n_idx;
                    r_whole    <= n_whole;
                    r_frac     <= n_frac;
                    r_fcnt     <= n_fcnt;
                    r_seen     <= n_seen;
                    r_angles   <= n_angles;
                end
            end
            if (w_take && i_tok.last) begin
                r_s_valid <= 1'b1;
            end else if (w_c_ready) begin
                r_s_valid <= 1'b0;
            end
            if (w_c_ready) begin
                r_o_valid <= r_s_valid;
                if (r_s_valid) begin
                    r_o_res <= n_o_res;
                end
            end
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule

@@ rtl/three_angle_command_parser.sv @@
// Top level of the three-angle command parser: stream ports, APB register.
// Uses tacp_pkg, tacp_front, tacp_queue and tacp_back.
//
// Feed one byte of a command line per transfer on s_axis, the final byte with
// tlast set; the block accepts one byte every cycle while the token queue has
// room. Each line gives one result transfer: a valid flag and three angles in
// centidegrees (all zero for a rejected line). m_axis_tvalid rises once the
// final byte has passed through the token queue into the parser and through the
// closing stage into the result register. The parser updates its state once per
// byte. While a result waits on m_axis, one more line can close into the
// closing stage; the final byte after that holds the parser, bytes back up in
// the four-entry token queue, and s_axis_tready drops once it is full. The
// angle limit sits at APB address 0 and should only be changed while no line
// is in flight.
module three_angle_command_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tacp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] byte_value
    input  logic                                 s_axis_tlast,  // last_byte
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tacp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [0] line_valid, [20:1]
                                                                // angle_one, [40:21]
                                                                // angle_two, [60:41]
                                                                // angle_three, [63:61] zero
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tacp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tacp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tacp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [tacp_pkg::ANGLE_W-1:0] r_limit;
    logic                         w_limit_sel;

    logic              w_push, w_full, w_q_valid, w_pop;
    tacp_pkg::t_token  w_in_tok, w_q_tok;
    tacp_pkg::t_result w_res;

    // APB: single register, zero wait states
    assign pready      = 1'b1;
    assign w_limit_sel = (paddr[2] == tacp_pkg::CFG_IDX_ANGLE_LIMIT);
    assign prdata      = w_limit_sel
                       ? {{(tacp_pkg::APB_DATA_W - tacp_pkg::ANGLE_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tacp_pkg::ANGLE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && w_limit_sel) begin
            r_limit <= pwdata[tacp_pkg::ANGLE_W-1:0];
        end
    end

    // classify bytes into tokens
    tacp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_tok         (w_in_tok)
    );

    tacp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_in_tok),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_tok   (w_q_tok)
    );

    // parse tokens, close the line, hold the result
    tacp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_tok_valid (w_q_valid),
        .i_tok       (w_q_tok),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {{tacp_pkg::OUT_PAD_W{1'b0}}, w_res.angles, w_res.line_valid};

endmodule

@@ rtl/tacp_checker.sv @@
// Port-level checks for three_angle_command_parser, bound to the top level.
// Uses tacp_pkg.
module tacp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tacp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CAP = tacp_pkg::QUEUE_DEPTH + 2;

    logic [3:0] r_pend;   // lines taken but not yet delivered
    logic       w_in_end, w_out;

    assign w_in_end = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign w_out    = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({w_in_end, w_out})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[tacp_pkg::OUT_TDATA_W-1:1] == '0)
        else $error("rejected line carries nonzero angles");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != '0)
        else $error("result without a pending line");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'(CAP))
        else $error("more lines in flight than the block can hold");

endmodule

bind three_angle_command_parser tacp_checker u_tacp_checker (.*);

@@ sim/angle_result_checker.sv @@
// Result checker for three_angle_command_parser: follows byte and APB transfers,
// predicts the result of each line and compares the result stream against it.
// Depends on tacp_pkg for sizes and the result type.
module angle_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_byte_tvalid,
    input  logic                                i_byte_tready,
    input  logic [tacp_pkg::IN_TDATA_W-1:0]     i_byte_tdata,
    input  logic                                i_byte_tlast,
    input  logic                                i_res_tvalid,
    input  logic                                i_res_tready,
    input  logic [tacp_pkg::OUT_TDATA_W-1:0]    i_res_tdata,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [tacp_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [tacp_pkg::APB_DATA_W-1:0]     i_pwdata,
    input  logic [tacp_pkg::APB_DATA_W-1:0]     i_prdata,
    output int                                  o_fail_count,
    output int                                  o_lines_pending
);
    localparam int ANGLE_W   = tacp_pkg::ANGLE_W;
    localparam int WHOLE_CAP = (1 << tacp_pkg::WHOLE_W) - 1;
    localparam logic [tacp_pkg::APB_ADDR_W-1:0] LIMIT_ADDR =
        tacp_pkg::APB_ADDR_W'(4 * tacp_pkg::CFG_IDX_ANGLE_LIMIT);

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_WHOLE,
        PH_FRAC,
        PH_TRAIL,
        PH_FAIL
    } t_parse_phase;

    logic [ANGLE_W-1:0]    limit_q;
    t_parse_phase          phase;
    int unsigned           angle_idx;
    int unsigned           whole_acc;
    int unsigned           frac_acc;
    int unsigned           frac_cnt;
    bit                    digit_seen;
    logic [ANGLE_W-1:0]    done_ang [8];
    tacp_pkg::t_result     expected_lines [$];
    int                    fail_total = 0;
    int                    pending_q  = 0;
    string                 angle_name [3] = '{"angle_one", "angle_two", "angle_three"};

    assign o_fail_count    = fail_total;
    assign o_lines_pending = pending_q;

    function automatic bit is_sep(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_COMMA || b == CH_SEMI;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    task clear_line();
        phase      = PH_SKIP;
        angle_idx  = 0;
        whole_acc  = 0;
        frac_acc   = 0;
        frac_cnt   = 0;
        digit_seen = 0;
        foreach (done_ang[k]) done_ang[k] = '0;
    endtask

    // Close the angle in progress; a single fraction digit counts as tenths.
    task close_angle();
        int unsigned value;
        if (!digit_seen) begin
            phase = PH_FAIL;
            return;
        end
        value = whole_acc * 100 + ((frac_cnt == 1) ? frac_acc * 10 : frac_acc);
        if (value > limit_q || angle_idx >= tacp_pkg::ANGLE_COUNT) begin
            phase = PH_FAIL;
            return;
        end
        done_ang[angle_idx] = ANGLE_W'(value);
        angle_idx++;
        phase      = (angle_idx >= tacp_pkg::ANGLE_COUNT) ? PH_TRAIL : PH_SKIP;
        whole_acc  = 0;
        frac_acc   = 0;
        frac_cnt   = 0;
        digit_seen = 0;
    endtask

    // Byte seen while waiting for an angle, or after the last one.
    task between_angles(input logic [7:0] b);
        if (phase == PH_TRAIL) begin
            if (!(is_sep(b) || b == CH_CR || b == CH_LF))
                phase = PH_FAIL;
            return;
        end
        if (is_sep(b))
            return;
        if (is_digit(b)) begin
            phase      = PH_WHOLE;
            whole_acc  = b - CH_ZERO;
            digit_seen = 1;
        end else if (b == CH_DOT) begin
            phase = PH_FRAC;
        end else begin
            phase = PH_FAIL;
        end
    endtask

    task parse_byte(input logic [7:0] b, input logic fin);
        tacp_pkg::t_result r;
        int unsigned       w;
        case (phase)
            PH_WHOLE: begin
                if (is_digit(b)) begin
                    w         = whole_acc * 10 + (b - CH_ZERO);
                    whole_acc = (w > WHOLE_CAP) ? WHOLE_CAP : w;
                end else if (b == CH_DOT) begin
                    phase = PH_FRAC;
                end else begin
                    close_angle();
                    if (phase != PH_FAIL) between_angles(b);
                end
            end
            PH_FRAC: begin
                if (is_digit(b)) begin
                    if (frac_cnt < 2) begin
                        frac_acc   = frac_acc * 10 + (b - CH_ZERO);
                        frac_cnt++;
                        digit_seen = 1;
                    end else begin
                        phase = PH_FAIL;
                    end
                end else begin
                    close_angle();
                    if (phase != PH_FAIL) between_angles(b);
                end
            end
            PH_SKIP, PH_TRAIL: between_angles(b);
            default: ;
        endcase
        if (fin) begin
            if (phase == PH_WHOLE || phase == PH_FRAC)
                close_angle();
            r.line_valid = (phase == PH_TRAIL);
            for (int k = 0; k < tacp_pkg::OUT_ANGLES; k++)
                r.angles[k] = (r.line_valid && k < tacp_pkg::ANGLE_COUNT) ? done_ang[k] : '0;
            expected_lines.push_back(r);
            clear_line();
        end
    endtask

    task automatic check_field(input string name, input logic [ANGLE_W-1:0] want,
                               input logic [ANGLE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    task compare_result(input logic [tacp_pkg::OUT_TDATA_W-1:0] d);
        tacp_pkg::t_result want;
        if (expected_lines.size() == 0) begin
            $display("%0t: result with no line pending, expected none, got %h", $time, d);
            fail_total++;
            return;
        end
        want = expected_lines.pop_front();
        check_field("line_valid", ANGLE_W'(want.line_valid), ANGLE_W'(d[0]));
        for (int k = 0; k < tacp_pkg::OUT_ANGLES; k++)
            check_field(angle_name[k], want.angles[k], d[1 + k * ANGLE_W +: ANGLE_W]);
        check_field("pad bits", '0,
                    ANGLE_W'(d[tacp_pkg::OUT_TDATA_W-1 -: tacp_pkg::OUT_PAD_W]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_q = tacp_pkg::ANGLE_LIMIT_RESET;
            clear_line();
            expected_lines.delete();
        end else begin
            // a result never comes from a byte taken at the same edge
            if (i_res_tvalid && i_res_tready)
                compare_result(i_res_tdata);
            if (i_psel && i_penable && i_pready && i_paddr == LIMIT_ADDR) begin
                if (i_pwrite) begin
                    limit_q = i_pwdata[ANGLE_W-1:0];
                end else if (i_prdata !== tacp_pkg::APB_DATA_W'(limit_q)) begin
                    $display("%0t: angle_limit read expected %0d, got %0d",
                             $time, limit_q, i_prdata);
                    fail_total++;
                end
            end
            if (i_byte_tvalid && i_byte_tready)
                parse_byte(i_byte_tdata, i_byte_tlast);
        end
        pending_q <= expected_lines.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the parser testbench: clock, reset, byte and APB stimulus, verdict.
// Depends on tacp_pkg, three_angle_command_parser and angle_result_checker.
module testbench;

    typedef logic [7:0] t_byte_q [$];

    localparam int LINE_BYTES_PER_PHASE = 300;
    localparam int PHASES               = 6;
    localparam logic [tacp_pkg::APB_ADDR_W-1:0] LIMIT_ADDR =
        tacp_pkg::APB_ADDR_W'(4 * tacp_pkg::CFG_IDX_ANGLE_LIMIT);

    logic                                 i_clk         = 1'b0;
    logic                                 i_rst_n       = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [tacp_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;  // [7:0] byte_value
    logic                                 s_axis_tlast  = 1'b0; // last_byte
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [tacp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;  // [0] line_valid, [20:1] angle_one,
                                                         // [40:21] angle_two,
                                                         // [60:41] angle_three, [63:61] zero
    logic                                 psel          = 1'b0;
    logic                                 penable       = 1'b0;
    logic                                 pwrite        = 1'b0;
    logic [tacp_pkg::APB_ADDR_W-1:0]      paddr         = '0;
    logic [tacp_pkg::APB_DATA_W-1:0]      pwdata        = '0;
    logic [tacp_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;

    int          fail_count;
    int          lines_pending;
    bit          calm       = 1'b0;  // no idling on either side once set
    bit          gaps_on    = 1'b0;  // sender gaps allowed for the current line
    bit          stalls_on  = 1'b1;  // receiver stalls allowed in this stretch
    int unsigned stall_left = 0;
    int unsigned phase_bytes;

    always #5 i_clk = ~i_clk;

    three_angle_command_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    angle_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_tvalid   (s_axis_tvalid),
        .i_byte_tready   (s_axis_tready),
        .i_byte_tdata    (s_axis_tdata),
        .i_byte_tlast    (s_axis_tlast),
        .i_res_tvalid    (m_axis_tvalid),
        .i_res_tready    (m_axis_tready),
        .i_res_tdata     (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .o_fail_count    (fail_count),
        .o_lines_pending (lines_pending)
    );

    // Receiver back-pressure: random stall bursts, with stretches
    // where stalls are switched off altogether.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            stalls_on = !stalls_on;
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!calm && stalls_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        if (calm)
            stall_left = 0;
        m_axis_tready <= (stall_left == 0);
    end

    // One byte transfer; tvalid stays high into the next byte unless a gap
    // is inserted, so it never gets two assignments in one step.
    task push_byte(input logic [7:0] b, input logic fin);
        if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_bytes++;
    endtask

    // Lines follow each other directly; drain() drops tvalid after the last.
    task send_line(input t_byte_q line);
        gaps_on = ($urandom_range(0, 2) != 0);
        foreach (line[i])
            push_byte(line[i], i == line.size() - 1);
    endtask

    function automatic t_byte_q from_text(input string t);
        t_byte_q q;
        for (int i = 0; i < t.len(); i++)
            q.push_back(t[i]);
        return q;
    endfunction

    // Mostly well-formed lines with random content around the current limit;
    // the rest is noise, wrong angle counts, corrupted or cut-short lines.
    function automatic t_byte_q make_line(input logic [tacp_pkg::ANGLE_W-1:0] limit);
        t_byte_q q;
        string   seps     = " \t,;";
        string   tails    = " \t,;\r\n";
        string   specials = ".\r\n9";
        string   s;
        int      mode;
        int      n_angles;
        int      w;
        int      fd;
        int      pos;
        mode     = $urandom_range(0, 9);
        n_angles = tacp_pkg::ANGLE_COUNT;
        if (mode == 0) begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        if (mode == 1)
            n_angles = $urandom_range(0, tacp_pkg::ANGLE_COUNT + 1);
        for (int k = 0; k < n_angles; k++) begin
            // zero separators between angles gives abutting numbers
            repeat ((k == 0) ? $urandom_range(0, 2) : $urandom_range(0, 3))
                q.push_back(seps[$urandom_range(0, 3)]);
            if ($urandom_range(0, 19) == 0)
                continue;  // missing angle
            case ($urandom_range(0, 5))
                0:       w = 0;
                1:       w = $urandom_range(0, 9);
                2:       w = $urandom_range(0, 999);
                5:       w = $urandom_range(10000, 99999999);  // saturating whole part
                default: w = int'(limit / 100) - 1 + $urandom_range(0, 2);
            endcase
            if (w < 0) w = 0;
            case ($urandom_range(0, 7))
                0, 1:    fd = 0;
                2, 3:    fd = 1;
                7:       fd = 3;
                default: fd = 2;
            endcase
            if (!(fd > 0 && $urandom_range(0, 2) == 0)) begin
                if ($urandom_range(0, 7) == 0) q.push_back("0");
                s = $sformatf("%0d", w);
                for (int j = 0; j < s.len(); j++) q.push_back(s[j]);
            end
            if (fd > 0 || $urandom_range(0, 7) == 0) begin
                q.push_back(".");
                repeat (fd) q.push_back(8'("0") + 8'($urandom_range(0, 9)));
            end
        end
        repeat ($urandom_range(0, 3)) q.push_back(tails[$urandom_range(0, 5)]);
        if (q.size() == 0)
            q.push_back(8'($urandom_range(0, 255)));
        if (mode == 2) begin
            pos = $urandom_range(0, q.size() - 1);
            q[pos] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                  : specials[$urandom_range(0, 3)];
        end
        if (mode == 3 && q.size() > 1)
            repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
        return q;
    endfunction

    // Setup cycle, then access cycle; the register takes the write at the
    // edge that ends the access cycle. An idle cycle follows.
    task apb_access(input logic wr, input logic [tacp_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (lines_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        string       directed [5];
        int unsigned limits [PHASES];
        int unsigned cur_limit;
        directed = '{"1.2.3.4", "360,0;.5\t\n", "0 0 0.999", ".", ","};
        limits   = '{36000, 0, 1000000, $urandom_range(0, 1000000), 150, 36000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, '0);  // reset value of the limit

        // directed lines at the reset limit: abutting angles, limit edge,
        // tenths, third fraction digit, bare dot, missing angles
        foreach (directed[i])
            send_line(from_text(directed[i]));

        for (int p = 0; p < PHASES; p++) begin
            cur_limit = limits[p];
            if (p != 0) begin
                drain();
                apb_access(1'b1, cur_limit);
                apb_access(1'b0, '0);
            end
            if (p == PHASES - 1)
                calm = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < LINE_BYTES_PER_PHASE)
                send_line(make_line(tacp_pkg::ANGLE_W'(cur_limit)));
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
